[rtl/wtm_pkg.sv]
// ----------------------------------------------------------------------------
// wtm_pkg
// types and constants shared by the four-channel wavetable mixer
// ----------------------------------------------------------------------------
package wtm_pkg;

    localparam int CHANNELS       = 4;
    localparam int WAVE_LENGTH    = 64;
    localparam int PHASE_FRACTION = 256;
    localparam int VOLUME_MAX     = 15;
    localparam int SAMPLE_BITS    = 12;

    localparam int ADDR_W   = $clog2(WAVE_LENGTH);
    localparam int FRAC_W   = $clog2(PHASE_FRACTION);
    localparam int PHASE_W  = ADDR_W + FRAC_W;
    localparam int STEP_W   = 14;
    localparam int VOL_W    = 4;
    localparam int LIMIT_W  = 12;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam int SUM_W       = $clog2(CHANNELS * ((2 ** SAMPLE_BITS) - 1) * VOLUME_MAX + 1);
    localparam int DIVISOR     = 2 * VOLUME_MAX;
    localparam int RECIP_SHIFT = SUM_W + $clog2(DIVISOR);
    localparam int RECIP       = ((2 ** RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int RECIP_W     = RECIP_SHIFT - $clog2(DIVISOR) + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_0       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_3       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUMES      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 3'd5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd4095;

    typedef struct packed {
        logic [1:0]             cmd;
        logic [1:0]             channel;
        logic [ADDR_W-1:0]      table_index;
        logic [SAMPLE_BITS-1:0] sample_value;
    } in_beat_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] mixed_sample;
        logic               clipped;
    } out_beat_t;

    typedef struct packed {
        logic                   wr_en;
        logic [ADDR_W-1:0]      wr_addr;
        logic [SAMPLE_BITS-1:0] wr_data;
        logic                   rd_en;
        logic [ADDR_W-1:0]      rd_addr;
    } bank_ctrl_t;

endpackage

[rtl/wavetable_mixer_4ch.sv]
// ----------------------------------------------------------------------------
// wavetable_mixer_4ch
// four-channel wavetable mixer: per-channel wave memories, phase accumulators,
// volume-weighted sum divided by twice the full volume, clamped to a limit
// ----------------------------------------------------------------------------
// a tick beat's result passes through the wave-memory read, sum, quotient and output registers
// throughput: one beat per cycle; the result pipeline drains into an output
// register, so input is taken while a result waits unless all stages are full
// load and clear beats give no result
// reset: phases, steps and volumes zero, limit 4095, wave memories read zero
// through valid bits until written; no clearing pass
module wavetable_mixer_4ch
    import wtm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_beat_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_beat_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [STEP_W-1:0]  step_reg [CHANNELS];
    logic [CFG_W-1:0]   volumes_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [PHASE_W-1:0] phase_reg [CHANNELS];
    logic [PHASE_W-1:0] phase_next [CHANNELS];

    logic                   s1_valid_reg;
    logic                   s2_valid_reg;
    logic                   s3_valid_reg;
    logic                   out_valid_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_next;
    logic [QUOT_W-1:0]      quot_reg;
    logic [PROD_W-1:0]      quot_prod;
    out_beat_t              out_data_reg;
    out_beat_t              out_data_next;

    logic out_free;
    logic s3_free;
    logic s2_free;
    logic s1_free;
    logic in_accept;
    logic tick_accept;

    bank_ctrl_t             bank_ctrl [CHANNELS];
    logic [SAMPLE_BITS-1:0] bank_data [CHANNELS];

    // stall chain, bubbles collapse
    assign out_free  = !out_valid_reg || out_ready;
    assign s3_free   = !s3_valid_reg || out_free;
    assign s2_free   = !s2_valid_reg || s3_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign in_ready  = s1_free;
    assign in_accept = in_valid && in_ready;
    assign tick_accept = in_accept && (in_data.cmd == CMD_TICK);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                step_reg[c] <= '0;
            end
            volumes_reg <= '0;
            limit_reg   <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            priority if (cfg_index <= REG_STEP_3)
            begin
                step_reg[cfg_index[1:0] - REG_STEP_0[1:0]] <= cfg_data[STEP_W-1:0];
            end
            else if (cfg_index == REG_VOLUMES)
            begin
                volumes_reg <= cfg_data;
            end
            else if (cfg_index == REG_OUTPUT_LIMIT)
            begin
                limit_reg <= cfg_data[LIMIT_W-1:0];
            end
            else
            begin
                // other indexes ignored
            end
        end
    end

    // phase accumulators, wrap is the natural modulo of the phase width
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            phase_next[c] = phase_reg[c];
            if (tick_accept)
            begin
                phase_next[c] = phase_reg[c] + step_reg[c];
            end
            else if (in_accept && (in_data.cmd == CMD_CLEAR) && (in_data.channel == 2'(c)))
            begin
                phase_next[c] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                phase_reg[c] <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                phase_reg[c] <= phase_next[c];
            end
        end
    end

    // wave memories, read at the current phase when a tick is taken
    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_bank
        always_comb
        begin
            bank_ctrl[g].wr_en   = in_accept && (in_data.cmd == CMD_LOAD)
                                   && (in_data.channel == 2'(g));
            bank_ctrl[g].wr_addr = in_data.table_index;
            bank_ctrl[g].wr_data = in_data.sample_value;
            bank_ctrl[g].rd_en   = tick_accept;
            bank_ctrl[g].rd_addr = phase_reg[g][PHASE_W-1 -: ADDR_W];
        end

        wtm_wave_bank u_bank
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (bank_ctrl[g]),
            .rd_data (bank_data[g])
        );
    end

    // weighted sum
    always_comb
    begin
        logic [VOL_W-1:0] vol;
        sum_next = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            vol = volumes_reg[VOL_W*c +: VOL_W];
            if (vol > VOL_W'(VOLUME_MAX))
            begin
                vol = VOL_W'(VOLUME_MAX);
            end
            sum_next = sum_next + SUM_W'(bank_data[c] * vol);
        end
    end

    // divide by the constant through a reciprocal, exact over the sum range
    assign quot_prod = PROD_W'(sum_reg) * PROD_W'(RECIP);

    always_comb
    begin
        if (quot_reg > QUOT_W'(limit_reg))
        begin
            out_data_next.mixed_sample = limit_reg;
            out_data_next.clipped      = 1'b1;
        end
        else
        begin
            out_data_next.mixed_sample = quot_reg[LIMIT_W-1:0];
            out_data_next.clipped      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= tick_accept;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_free)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
        begin
            sum_reg <= sum_next;
        end
        if (s3_free && s2_valid_reg)
        begin
            quot_reg <= quot_prod[RECIP_SHIFT +: QUOT_W];
        end
        if (out_free && s3_valid_reg)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.clipped) |-> (out_data_reg.mixed_sample == limit_reg))
        else $error("clipped beat not at output limit");

    a_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.mixed_sample <= limit_reg))
        else $error("output beat above limit");

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    a_tick_enters: assert property (@(posedge clk) disable iff (!rst_n)
        tick_accept |=> s1_valid_reg)
        else $error("tick beat lost at first stage");

    a_clear_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_data.cmd == CMD_CLEAR))
        |=> (phase_reg[$past(in_data.channel)] == '0))
        else $error("phase not cleared");

endmodule

[rtl/wtm_wave_bank.sv]
// ----------------------------------------------------------------------------
// wtm_wave_bank
// one channel's waveform memory, one write and one registered read per cycle;
// entries never written read as zero through per-entry valid bits
// ----------------------------------------------------------------------------
module wtm_wave_bank
    import wtm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  bank_ctrl_t             ctrl,
    output logic [SAMPLE_BITS-1:0] rd_data
);

    logic [SAMPLE_BITS-1:0] wave_mem [WAVE_LENGTH];
    logic [WAVE_LENGTH-1:0] written_reg;
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            wave_mem[ctrl.wr_addr] <= ctrl.wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= wave_mem[ctrl.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.wr_en)
            begin
                written_reg[ctrl.wr_addr] <= 1'b1;
            end
            if (ctrl.rd_en)
            begin
                rd_written_reg <= written_reg[ctrl.rd_addr];
            end
        end
    end

    assign rd_data = rd_written_reg ? rd_data_reg : '0;

endmodule

[test/wavetable_mixer_4ch_check.sv]
// ----------------------------------------------------------------------------
// wavetable_mixer_4ch_check
// watches the beat channels and register writes of the wavetable mixer, keeps
// its own copy of phases, wave memories and registers, works out each tick's
// mixed sample and compares it with the result beats in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wavetable_mixer_4ch_check
    import wtm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  in_beat_t             in_data,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  out_beat_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 flush,
    output int                   fails,
    output int                   pending
);

    logic [STEP_W-1:0]      step_q  [CHANNELS];
    logic [PHASE_W-1:0]     phase_q [CHANNELS];
    logic [SAMPLE_BITS-1:0] wave_q  [CHANNELS][WAVE_LENGTH];
    logic [CFG_W-1:0]       vol_word;
    logic [LIMIT_W-1:0]     limit_q;
    out_beat_t              mixes_due [$];
    bit                     flushed;

    task automatic report(input string what);
        fails++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        int unsigned       sum;
        int unsigned       quot;
        logic [VOL_W-1:0]  vol;
        logic [ADDR_W-1:0] pos;
        out_beat_t         want;

        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                step_q[c]  = '0;
                phase_q[c] = '0;
                for (int i = 0; i < WAVE_LENGTH; i++)
                begin
                    wave_q[c][i] = '0;
                end
            end
            vol_word = '0;
            limit_q  = LIMIT_RESET;
            mixes_due.delete();
        end
        else
        begin
            // result beat
            if (out_valid && out_ready)
            begin
                if (mixes_due.size() == 0)
                begin
                    report($sformatf("result beat %0d/%0d with nothing expected",
                                     out_data.mixed_sample, out_data.clipped));
                end
                else
                begin
                    want = mixes_due.pop_front();
                    if (out_data.mixed_sample !== want.mixed_sample)
                    begin
                        report($sformatf("mixed_sample got %0d want %0d",
                                         out_data.mixed_sample, want.mixed_sample));
                    end
                    if (out_data.clipped !== want.clipped)
                    begin
                        report($sformatf("clipped got %0b want %0b",
                                         out_data.clipped, want.clipped));
                    end
                end
            end

            // input beat
            if (in_valid && in_ready)
            begin
                case (in_data.cmd)
                    CMD_TICK:
                    begin
                        sum = 0;
                        for (int c = 0; c < CHANNELS; c++)
                        begin
                            vol = vol_word[VOL_W*c +: VOL_W];
                            if (vol > VOLUME_MAX)
                            begin
                                vol = VOL_W'(VOLUME_MAX);
                            end
                            pos = phase_q[c][PHASE_W-1 -: ADDR_W];
                            sum += int'(wave_q[c][pos]) * int'(vol);
                        end
                        quot = sum / DIVISOR;
                        if (quot > limit_q)
                        begin
                            want.mixed_sample = limit_q;
                            want.clipped      = 1'b1;
                        end
                        else
                        begin
                            want.mixed_sample = LIMIT_W'(quot);
                            want.clipped      = 1'b0;
                        end
                        mixes_due.push_back(want);
                        // phases move only after the mix
                        for (int c = 0; c < CHANNELS; c++)
                        begin
                            phase_q[c] = phase_q[c] + PHASE_W'(step_q[c]);
                        end
                    end
                    CMD_LOAD:
                    begin
                        wave_q[in_data.channel][in_data.table_index] = in_data.sample_value;
                    end
                    CMD_CLEAR:
                    begin
                        phase_q[in_data.channel] = '0;
                    end
                    default:
                    begin
                        // unused command, ignored
                    end
                endcase
            end

            if (cfg_we)
            begin
                if (cfg_index <= REG_STEP_3)
                begin
                    step_q[cfg_index[1:0] - REG_STEP_0[1:0]] = cfg_data[STEP_W-1:0];
                end
                else if (cfg_index == REG_VOLUMES)
                begin
                    vol_word = cfg_data;
                end
                else if (cfg_index == REG_OUTPUT_LIMIT)
                begin
                    limit_q = cfg_data[LIMIT_W-1:0];
                end
            end

            // end of run: whatever is still waiting never came
            if (flush && !flushed)
            begin
                flushed = 1'b1;
                while (mixes_due.size() != 0)
                begin
                    want = mixes_due.pop_front();
                    report($sformatf("expected result %0d/%0d never came",
                                     want.mixed_sample, want.clipped));
                end
            end
        end
        pending = mixes_due.size();
    end

endmodule

[test/wavetable_mixer_4ch_test.sv]
// ----------------------------------------------------------------------------
// wavetable_mixer_4ch_test
// drives the four-channel wavetable mixer with directed edge cases and random
// phases of loads, ticks and clears under varied register settings, with
// random idling on both sides and one long output hold-off
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wavetable_mixer_4ch_test;
    import wtm_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int HALF_PERIOD  = 5;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASES       = 8;
    localparam int PHASE_BEATS  = 180;
    localparam int CYCLE_LIMIT  = 200000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_beat_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_beat_t            out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 flush     = 1'b0;

    int fails;
    int pending;
    int cycles = 0;
    bit calm    = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    wavetable_mixer_4ch dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wavetable_mixer_4ch_check mix_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .flush     (flush),
        .fails     (fails),
        .pending   (pending)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            out_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_done = 1'b1;
        end
        out_ready = calm || ($urandom_range(99) >= 30);
    end

    function automatic in_beat_t beat(input logic [1:0] cmd, input logic [1:0] ch,
                                      input logic [ADDR_W-1:0] idx,
                                      input logic [SAMPLE_BITS-1:0] val);
        in_beat_t b;
        b.cmd          = cmd;
        b.channel      = ch;
        b.table_index  = idx;
        b.sample_value = val;
        return b;
    endfunction

    function automatic in_beat_t random_beat();
        int                     pick;
        logic [1:0]             cmd;
        logic [SAMPLE_BITS-1:0] val;
        pick = $urandom_range(99);
        if (pick < 40)
            cmd = CMD_LOAD;
        else if (pick < 85)
            cmd = CMD_TICK;
        else if (pick < 95)
            cmd = CMD_CLEAR;
        else
            cmd = CMD_UNUSED;
        case ($urandom_range(7))
            0:       val = '0;
            1:       val = '1;
            default: val = SAMPLE_BITS'($urandom);
        endcase
        return beat(cmd, 2'($urandom_range(3)), ADDR_W'($urandom_range(WAVE_LENGTH - 1)), val);
    endfunction

    // called and left at a falling edge
    task automatic send_beat(input in_beat_t b);
        while (!calm && $urandom_range(99) < 30)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // wait until every tick's result has come out, then let the pipeline drain
    task automatic settle();
        in_valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic pick_config();
        logic [STEP_W-1:0]  step;
        logic [CFG_W-1:0]   vols;
        logic [LIMIT_W-1:0] limit;
        for (int c = 0; c < CHANNELS; c++)
        begin
            case ($urandom_range(5))
                0:       step = '0;
                1:       step = '1;
                2:       step = STEP_W'($urandom_range(512));
                default: step = STEP_W'($urandom);
            endcase
            write_reg(REG_STEP_0 + CFG_IDX_W'(c), CFG_W'(step));
        end
        case ($urandom_range(5))
            0:       vols = '1;
            1:       vols = '0;
            default: vols = CFG_W'($urandom);
        endcase
        write_reg(REG_VOLUMES, vols);
        case ($urandom_range(5))
            0:       limit = '0;
            1:       limit = '1;
            2:       limit = LIMIT_W'($urandom_range(255));
            default: limit = LIMIT_W'($urandom);
        endcase
        write_reg(REG_OUTPUT_LIMIT, CFG_W'(limit));
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // silent wave straight after reset
        send_beat(beat(CMD_TICK, '1, '1, '1));
        settle();
        write_reg(REG_STEP_0, CFG_W'({STEP_W{1'b1}}));
        write_reg(REG_STEP_0 + CFG_IDX_W'(1), '0);
        write_reg(REG_STEP_0 + CFG_IDX_W'(2), CFG_W'(PHASE_FRACTION));
        write_reg(REG_STEP_3, CFG_W'(1));
        write_reg(REG_VOLUMES, '1);
        write_reg(REG_OUTPUT_LIMIT, CFG_W'(LIMIT_RESET));
        send_beat(beat(CMD_TICK, '0, '0, '0));
        for (int c = 0; c < CHANNELS; c++)
        begin
            send_beat(beat(CMD_LOAD, 2'(c), '0, '1));
        end
        send_beat(beat(CMD_LOAD, 2'd0, '1, '1));
        send_beat(beat(CMD_LOAD, 2'd3, '1, SAMPLE_BITS'(1)));
        // full scale on three channels clips
        send_beat(beat(CMD_TICK, '0, '0, '0));
        send_beat(beat(CMD_TICK, '1, '1, '1));
        send_beat(beat(CMD_CLEAR, 2'd0, '1, '1));
        send_beat(beat(CMD_CLEAR, 2'd3, '0, '0));
        send_beat(beat(CMD_TICK, '0, '0, '0));
        send_beat(beat(CMD_UNUSED, '1, '1, '1));
        send_beat(beat(CMD_LOAD, 2'd2, ADDR_W'(1), '0));
        send_beat(beat(CMD_TICK, '0, '0, '0));
        settle();
        write_reg(REG_OUTPUT_LIMIT, '0);
        send_beat(beat(CMD_TICK, '0, '0, '0));
        settle();
        write_reg(REG_VOLUMES, 16'h84C1);
        write_reg(REG_OUTPUT_LIMIT, CFG_W'(100));
        send_beat(beat(CMD_TICK, '0, '0, '0));
        send_beat(beat(CMD_TICK, '0, '0, '0));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            pick_config();
            calm = (ph == 2);
            if (ph == 4)
            begin
                // output held off while ticks keep coming
                hold_req = 1'b1;
                calm     = 1'b1;
                repeat (60) send_beat(beat(CMD_TICK, 2'($urandom), 6'($urandom), 12'($urandom)));
                calm     = 1'b0;
            end
            repeat (PHASE_BEATS) send_beat(random_beat());
        end
        calm = 1'b0;
        settle();
        flush = 1'b1;
        @(negedge clk);
        @(negedge clk);

        if (fails == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
